/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// types and constants shared by the matrix to quaternion blocks
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int QueueDepth = 4;
  localparam int RootBits   = 16;
  localparam int QuoBits    = 16;
  localparam int QOne       = 16384;

  typedef enum logic [1:0] {
    DOM_W = 2'd0,
    DOM_X = 2'd1,
    DOM_Y = 2'd2,
    DOM_Z = 2'd3
  } rmq_dom_t;

  // classified item: root argument and the three numerators in field order
  typedef struct packed {
    rmq_dom_t          dom;
    logic [16:0]       arg;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } rmq_item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] quo;
    logic [16:0] dv;
    logic        neg;
    logic        ovf;
    logic        zero;
  } rmq_lane_t;

endpackage

`default_nettype wire

/* hdl/rmq_if.sv */
// ----------------------------------------------------------------------------
// rmq interfaces
// matrix and quaternion channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r0_c0;
  logic signed [15:0] r0_c1;
  logic signed [15:0] r0_c2;
  logic signed [15:0] r1_c0;
  logic signed [15:0] r1_c1;
  logic signed [15:0] r1_c2;
  logic signed [15:0] r2_c0;
  logic signed [15:0] r2_c1;
  logic signed [15:0] r2_c2;
  modport source (output valid, r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2,
                  r2_c0, r2_c1, r2_c2, input ready);
  modport sink (input valid, r0_c0, r0_c1, r0_c2, r1_c0, r1_c1, r1_c2,
                r2_c0, r2_c1, r2_c2, output ready);
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// accepts a matrix, picks the dominant component, forms root argument
// and numerators, holds the result in one register
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  rmq_mat_if.sink            mat,
  output rmq_pkg::rmq_item_t item,
  output logic               item_valid,
  input  wire logic          item_ready
);
  import rmq_pkg::*;

  logic signed [18:0] e00, e11, e22, t, arg_s;
  logic               ypick, zpick;
  logic signed [15:0] big;
  rmq_item_t          cls;
  rmq_item_t          fitem;
  logic               fv;

  always_comb begin
    e00   = 19'(mat.r0_c0);
    e11   = 19'(mat.r1_c1);
    e22   = 19'(mat.r2_c2);
    t     = e00 + e11 + e22;
    ypick = mat.r1_c1 > mat.r0_c0;
    big   = ypick ? mat.r1_c1 : mat.r0_c0;
    zpick = mat.r2_c2 > big;
    if (t > 19'sd0) begin
      cls.dom = DOM_W;
      arg_s   = t + 19'(QOne);
      cls.n0  = 17'(mat.r1_c2) - 17'(mat.r2_c1);
      cls.n1  = 17'(mat.r2_c0) - 17'(mat.r0_c2);
      cls.n2  = 17'(mat.r0_c1) - 17'(mat.r1_c0);
    end else if (zpick) begin
      cls.dom = DOM_Z;
      arg_s   = e22 - e00 - e11 + 19'(QOne);
      cls.n0  = 17'(mat.r0_c1) - 17'(mat.r1_c0);
      cls.n1  = 17'(mat.r2_c0) + 17'(mat.r0_c2);
      cls.n2  = 17'(mat.r2_c1) + 17'(mat.r1_c2);
    end else if (ypick) begin
      cls.dom = DOM_Y;
      arg_s   = e11 - e22 - e00 + 19'(QOne);
      cls.n0  = 17'(mat.r2_c0) - 17'(mat.r0_c2);
      cls.n1  = 17'(mat.r1_c0) + 17'(mat.r0_c1);
      cls.n2  = 17'(mat.r1_c2) + 17'(mat.r2_c1);
    end else begin
      cls.dom = DOM_X;
      arg_s   = e00 - e11 - e22 + 19'(QOne);
      cls.n0  = 17'(mat.r1_c2) - 17'(mat.r2_c1);
      cls.n1  = 17'(mat.r0_c1) + 17'(mat.r1_c0);
      cls.n2  = 17'(mat.r0_c2) + 17'(mat.r2_c0);
    end
    cls.arg = (arg_s > 19'sd0) ? arg_s[16:0] : 17'd0;
  end

  assign mat.ready  = !fv || item_ready;
  assign item       = fitem;
  assign item_valid = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (mat.valid && mat.ready) begin
      fv <= 1'b1;
    end else if (item_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mat.valid && mat.ready) begin
      fitem <= cls;
    end
  end

endmodule

`default_nettype wire

/* hdl/rmq_queue.sv */
// ----------------------------------------------------------------------------
// rmq_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_queue #(
  parameter int DEPTH = rmq_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rmq_pkg::rmq_item_t wr_item,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output rmq_pkg::rmq_item_t rd_item,
  output logic               rd_valid,
  input  wire logic          rd_pop
);
  import rmq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rmq_item_t     mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic          push, pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// pipelined square root, one bit per stage, then three pipelined
// dividers, saturation and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rmq_pkg::rmq_item_t item,
  input  wire logic          item_valid,
  output logic               item_pop,
  rmq_quat_if.source         quat
);
  import rmq_pkg::*;

  logic adv;
  logic ov;

  assign adv      = !ov || quat.ready;
  assign item_pop = adv;

  // square root stages
  logic      sv   [RootBits+1];
  rmq_item_t sitm [RootBits+1];
  logic [31:0] srem  [RootBits+1];
  logic [15:0] sroot [RootBits+1];

  assign sv[0]    = item_valid;
  assign sitm[0]  = item;
  assign srem[0]  = {1'b0, item.arg, 14'd0};
  assign sroot[0] = '0;

  for (genvar k = 0; k < RootBits; k++) begin : g_root
    localparam int I = RootBits - 1 - k;
    logic [32:0] d;
    logic [31:0] rem_n;
    logic [15:0] root_n;
    always_comb begin
      d = ({17'd0, sroot[k]} << (I + 1)) | (33'd1 << (2 * I));
      if ({1'b0, srem[k]} >= d) begin
        rem_n  = srem[k] - d[31:0];
        root_n = sroot[k] | (16'd1 << I);
      end else begin
        rem_n  = srem[k];
        root_n = sroot[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sitm[k+1]  <= sitm[k];
        srem[k+1]  <= rem_n;
        sroot[k+1] <= root_n;
      end
    end
  end

  // divider setup
  logic [15:0] s;
  logic [16:0] half_n;
  logic signed [16:0] nsel [3];
  rmq_lane_t   lane_n [3];

  assign s       = sroot[RootBits];
  assign half_n  = ({1'b0, s} + 17'd1) >> 1;
  assign nsel[0] = sitm[RootBits].n0;
  assign nsel[1] = sitm[RootBits].n1;
  assign nsel[2] = sitm[RootBits].n2;

  for (genvar l = 0; l < 3; l++) begin : g_setup
    logic [16:0] mag;
    logic [31:0] dd;
    always_comb begin
      mag            = nsel[l][16] ? 17'(-nsel[l]) : 17'(nsel[l]);
      dd             = {1'b0, mag, 14'd0} + {16'd0, s};
      lane_n[l].rem  = dd;
      lane_n[l].quo  = '0;
      lane_n[l].dv   = {s, 1'b0};
      lane_n[l].neg  = nsel[l][16];
      lane_n[l].ovf  = {1'b0, dd} >= {lane_n[l].dv, 16'd0};
      lane_n[l].zero = s == 16'd0;
    end
  end

  logic      dv   [QuoBits+1];
  rmq_dom_t  ddom [QuoBits+1];
  logic [15:0] dhalf [QuoBits+1];
  rmq_lane_t dl [3][QuoBits+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[RootBits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ddom[0]  <= sitm[RootBits].dom;
      dhalf[0] <= half_n[15:0];
      dl[0][0] <= lane_n[0];
      dl[1][0] <= lane_n[1];
      dl[2][0] <= lane_n[2];
    end
  end

  // divider stages
  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int I = QuoBits - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ddom[k+1]  <= ddom[k];
        dhalf[k+1] <= dhalf[k];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] sh;
      rmq_lane_t   nx;
      always_comb begin
        sh = {16'd0, dl[l][k].dv} << I;
        nx = dl[l][k];
        if ({1'b0, dl[l][k].rem} >= sh) begin
          nx.rem = dl[l][k].rem - sh[31:0];
          nx.quo = dl[l][k].quo | (16'd1 << I);
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dl[l][k+1] <= nx;
        end
      end
    end
  end

  // saturation and field placement
  logic signed [15:0] res [3];
  logic signed [15:0] fw, fx, fy, fz;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    rmq_lane_t fin;
    always_comb begin
      fin = dl[l][QuoBits];
      if (fin.zero) begin
        res[l] = '0;
      end else if (fin.neg) begin
        if (fin.ovf || fin.quo > 16'd32768) begin
          res[l] = -16'sd32768;
        end else begin
          res[l] = 16'(-fin.quo);
        end
      end else if (fin.ovf || fin.quo > 16'd32767) begin
        res[l] = 16'sd32767;
      end else begin
        res[l] = signed'(fin.quo);
      end
    end
  end

  always_comb begin
    case (ddom[QuoBits])
      DOM_W: begin
        fw = signed'(dhalf[QuoBits]); fx = res[0]; fy = res[1]; fz = res[2];
      end
      DOM_X: begin
        fw = res[0]; fx = signed'(dhalf[QuoBits]); fy = res[1]; fz = res[2];
      end
      DOM_Y: begin
        fw = res[0]; fx = res[1]; fy = signed'(dhalf[QuoBits]); fz = res[2];
      end
      default: begin
        fw = res[0]; fx = res[1]; fy = res[2]; fz = signed'(dhalf[QuoBits]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= dv[QuoBits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat.quat_w <= fw;
      quat.quat_x <= fx;
      quat.quat_y <= fy;
      quat.quat_z <= fz;
    end
  end

  assign quat.valid = ov;

endmodule

`default_nettype wire

/* hdl/rotation_matrix_to_quaternion_top.sv */
// rate: one item per cycle unless stalled, 16 stage root and divider pipes
// a stall at the output freezes the back pipe; the queue absorbs the front
// reset: synchronous active high rst empties front register, queue and pipe
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// rotation matrix to quaternion, signed Q2.14 in and out
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_top #(
  parameter int QUEUE_DEPTH = rmq_pkg::QueueDepth
) (
  input wire logic   clk,
  input wire logic   rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);
  import rmq_pkg::*;

  rmq_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_pop;

  rmq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mat        (mat),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  rmq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  rmq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .quat       (quat)
  );

endmodule

`default_nettype wire

/* test/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// watches the matrix and quaternion channels, computes the expected
// quaternion of every accepted matrix and compares results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmq_checker (
  input wire logic clk,
  input wire logic rst,
  rmq_mat_if.sink  mat_mon,
  rmq_quat_if.sink quat_mon,
  output int       errors,
  output int       pending
);
  import rmq_pkg::*;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_root(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 60;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint quot_round(longint num, longint s);
    longint mag;
    longint q;
    if (s == 0) return 0;
    mag = (num < 0) ? -num : num;
    q = (mag * 16384 + s) / (2 * s);
    return sat16((num < 0) ? -q : q);
  endfunction

  function automatic quat_t matrix_to_quat(longint a00, longint a01, longint a02,
                                           longint a10, longint a11, longint a12,
                                           longint a20, longint a21, longint a22);
    longint t;
    longint arg;
    longint s;
    longint h;
    longint w, x, y, z;
    rmq_dom_t dom;
    quat_t res;
    t = a00 + a11 + a22;
    if (t > 0) begin
      dom = DOM_W;
      arg = t + QOne;
    end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
      dom = DOM_Z;
      arg = a22 - (a00 + a11) + QOne;
    end else if (a11 > a00) begin
      dom = DOM_Y;
      arg = a11 - (a22 + a00) + QOne;
    end else begin
      dom = DOM_X;
      arg = a00 - (a11 + a22) + QOne;
    end
    s = (arg <= 0) ? 0 : int_root(arg * QOne);
    h = sat16((s + 1) >> 1);
    case (dom)
      DOM_W: begin
        w = h; x = quot_round(a12 - a21, s);
        y = quot_round(a20 - a02, s); z = quot_round(a01 - a10, s);
      end
      DOM_Z: begin
        w = quot_round(a01 - a10, s); x = quot_round(a20 + a02, s);
        y = quot_round(a21 + a12, s); z = h;
      end
      DOM_Y: begin
        w = quot_round(a20 - a02, s); x = quot_round(a10 + a01, s);
        y = h; z = quot_round(a12 + a21, s);
      end
      default: begin
        w = quot_round(a12 - a21, s); x = h;
        y = quot_round(a01 + a10, s); z = quot_round(a02 + a20, s);
      end
    endcase
    res.w = w[15:0]; res.x = x[15:0]; res.y = y[15:0]; res.z = z[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    quat_t want;
    if (rst) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (mat_mon.valid && mat_mon.ready)
        quat_q.push_back(matrix_to_quat(mat_mon.r0_c0, mat_mon.r0_c1, mat_mon.r0_c2,
                                        mat_mon.r1_c0, mat_mon.r1_c1, mat_mon.r1_c2,
                                        mat_mon.r2_c0, mat_mon.r2_c1, mat_mon.r2_c2));
      if (quat_mon.valid && quat_mon.ready) begin
        if (quat_q.size() == 0) begin
          if (errors < 10) $display("unexpected quaternion at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = quat_q.pop_front();
          if (want.w !== quat_mon.quat_w || want.x !== quat_mon.quat_x ||
              want.y !== quat_mon.quat_y || want.z !== quat_mon.quat_z) begin
            if (errors < 10)
              $display("mismatch at %0t: want w %0d x %0d y %0d z %0d, got %0d %0d %0d %0d",
                       $realtime, want.w, want.x, want.y, want.z, quat_mon.quat_w,
                       quat_mon.quat_x, quat_mon.quat_y, quat_mon.quat_z);
            errors <= errors + 1;
          end
        end
      end
      pending <= quat_q.size();
    end
  end
endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// streams directed, rotation-like and random matrices through converter under
// varying sender gaps and receiver stalls; the checker compares quaternions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_pct;
  int   stall_pct;

  rmq_mat_if  mat ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion_top u_top (
    .clk  (clk),
    .rst  (rst),
    .mat  (mat.sink),
    .quat (quat.source)
  );

  rmq_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .mat_mon  (mat.sink),
    .quat_mon (quat.sink),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(negedge clk) begin
    if (rst) quat.ready <= 1'b0;
    else quat.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_matrix(input logic [15:0] e[9]);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    mat.r0_c0 <= e[0]; mat.r0_c1 <= e[1]; mat.r0_c2 <= e[2];
    mat.r1_c0 <= e[3]; mat.r1_c1 <= e[4]; mat.r1_c2 <= e[5];
    mat.r2_c0 <= e[6]; mat.r2_c1 <= e[7]; mat.r2_c2 <= e[8];
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(16384 - $urandom_range(200));
      3: return 16'(-16384 + $urandom_range(200));
      4: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_rotation();
    logic [15:0] e[9];
    int perm;
    int sg[3];
    perm = $urandom_range(5);
    for (int i = 0; i < 9; i++) e[i] = 16'($signed($urandom_range(600)) - 300);
    for (int i = 0; i < 3; i++) sg[i] = $urandom_range(1) ? 1 : -1;
    for (int r = 0; r < 3; r++) begin
      int c;
      c = (r + perm) % 3;
      if (perm >= 3) c = (perm - r + 3) % 3;
      e[r * 3 + c] = 16'(sg[r] * (16384 - int'($urandom_range(3000))));
    end
    send_matrix(e);
  endtask

  initial begin
    logic [15:0] e[9];
    rst = 1'b1;
    mat.valid = 1'b0;
    mat.r0_c0 = '0; mat.r0_c1 = '0; mat.r0_c2 = '0;
    mat.r1_c0 = '0; mat.r1_c1 = '0; mat.r1_c2 = '0;
    mat.r2_c0 = '0; mat.r2_c1 = '0; mat.r2_c2 = '0;
    quat.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // identity, half turns about each axis, zero, a quarter turn about z, extremes
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(e);
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(e);
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    e = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384}; send_matrix(e);
    for (int i = 0; i < 9; i++) e[i] = 16'h7fff;
    send_matrix(e);
    for (int i = 0; i < 9; i++) e[i] = 16'h8000;
    send_matrix(e);
    // large negative diagonals on the x and z branches
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(e);
    e = '{-20000, 100, 0, 0, -32768, 0, 0, 0, 0}; send_matrix(e);
    e = '{-32768, 0, 0, 0, -20000, 0, 0, 0, 32767}; send_matrix(e);
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(e);
    // large off-diagonal entries, then two diagonal-only cases
    e = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1}; send_matrix(e);
    e = '{-1, 32767, 32767, 32767, -16384, 32767, 32767, 32767, -16384};
    send_matrix(e);
    e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 1}; send_matrix(e);
    e = '{5000, 0, 0, 0, 5000, 0, 0, 0, 5000}; send_matrix(e);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 47 : (ph == 3) ? 25 : 0;
      stall_pct = (ph == 2) ? 47 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < 370; n++) begin
        if ($urandom_range(3) != 0) begin
          send_rotation();
        end else begin
          for (int i = 0; i < 9; i++) e[i] = rand_elem();
          send_matrix(e);
        end
      end
      // drain the pipe before the next phase
      mat.valid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) $display("** rotation_matrix_to_quaternion_top: PASSED **");
    else $display("** rotation_matrix_to_quaternion_top: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** rotation_matrix_to_quaternion_top: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
